[design/crc32c_pkg.sv]
// Shared types, constants and the CRC byte step for the CRC-32C stream engine.
`default_nettype none

package crc32c_pkg;

    // Reflected Castagnoli polynomial
    localparam logic [31:0] CRC_POLY  = 32'h82F63B78;
    localparam logic [31:0] CRC_ONES  = 32'hFFFF_FFFF;

    // Port widths fixed by the item format
    localparam int unsigned DATA_W    = 64;
    localparam int unsigned BCNT_W    = 4;
    localparam int unsigned CRC_W     = 32;

    // Saturated byte count: wide enough for the largest word size (8 bytes)
    localparam int unsigned CNT_W     = 5;

    // Decoupling queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = 2;
    localparam int unsigned QUEUE_CW    = 3;

    // Classified item as it travels through the queue
    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [CNT_W-1:0]  cnt;
        logic              first;
        logic              last;
    } t_item;

    // Fold one byte into the running register, LSB first
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] c_in,
                                                  input logic [7:0]       b);
        logic [CRC_W-1:0] c;
        c = c_in ^ {24'h000000, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : '0);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[design/crc32c_stream_engine.sv]
// Top level of the CRC-32C stream engine: front stage, queue and CRC back end.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-------------------------------------------
//  input    | in        | i_valid / o_stall  | i_data_word, i_byte_count, i_first_word,
//           |           |                    | i_last_word
//  output   | out       | o_valid / i_stall  | o_crc_value
//  config   | in        | i_cfg_wr_en        | i_cfg_wr_data (seed CRC)
//
//  One item per cycle sustained while o_stall is low; a word of up to WORD_BYTES bytes is folded whole.
//  From input accept, an item is loaded into the front register, then written to the queue; on pop
//  from the queue, the result of a last word is loaded into the result register.
//  Synchronous active-low reset clears the seed to 0 and the running CRC to all ones.
//  An output stall holds the result; behind a blocked last word the queue's other three entries
//  and the front register take four more items before o_stall rises.
`default_nettype none

module crc32c_stream_engine
    import crc32c_pkg::*;
#(
    parameter int unsigned WORD_BYTES = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // configuration
    input  wire logic              i_cfg_wr_en,
    input  wire logic [CRC_W-1:0]  i_cfg_wr_data,
    // input channel
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [DATA_W-1:0] i_data_word,
    input  wire logic [BCNT_W-1:0] i_byte_count,
    input  wire logic              i_first_word,
    input  wire logic              i_last_word,
    // output channel
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [CRC_W-1:0]       o_crc_value
);

    logic  push, pop, full, empty;
    t_item front_item, queue_item;

    crc32c_front #(
        .WORD_BYTES (WORD_BYTES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_data_word  (i_data_word),
        .i_byte_count (i_byte_count),
        .i_first_word (i_first_word),
        .i_last_word  (i_last_word),
        .o_push       (push),
        .o_item       (front_item),
        .i_full       (full)
    );

    crc32c_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_item  (queue_item),
        .o_full  (full),
        .o_empty (empty)
    );

    crc32c_back #(
        .WORD_BYTES (WORD_BYTES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_item        (queue_item),
        .i_empty       (empty),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_crc_value   (o_crc_value)
    );

endmodule

`default_nettype wire

[design/crc32c_front.sv]
// Front stage: accepts input items, saturates the byte count and hands them to the queue.
`default_nettype none

module crc32c_front
    import crc32c_pkg::*;
#(
    parameter int unsigned WORD_BYTES = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // input channel
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [DATA_W-1:0] i_data_word,
    input  wire logic [BCNT_W-1:0] i_byte_count,
    input  wire logic              i_first_word,
    input  wire logic              i_last_word,
    // toward the queue
    output logic                   o_push,
    output t_item                  o_item,
    input  wire logic              i_full
);

    logic  r_valid, n_valid;
    t_item r_item,  n_item;
    logic  take;
    logic [CNT_W-1:0] cnt_ext;

    // Hold the staged item while the queue is full
    assign o_push  = r_valid && !i_full;
    assign o_stall = r_valid && i_full;
    assign take    = i_valid && !o_stall;
    assign o_item  = r_item;

    // Classify: clamp the byte count to the word size
    assign cnt_ext = CNT_W'(i_byte_count);

    always_comb begin
        n_valid = r_valid;
        n_item  = r_item;
        if (o_push) begin
            n_valid = 1'b0;
        end
        if (take) begin
            n_valid      = 1'b1;
            n_item.data  = i_data_word;
            n_item.cnt   = (cnt_ext > CNT_W'(WORD_BYTES)) ? CNT_W'(WORD_BYTES) : cnt_ext;
            n_item.first = i_first_word;
            n_item.last  = i_last_word;
        end
    end

    // Advance the staging register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

endmodule

`default_nettype wire

[design/crc32c_queue.sv]
// Short FIFO that decouples the classifying front from the CRC back end.
`default_nettype none

module crc32c_queue
    import crc32c_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    input  wire logic  i_pop,
    output t_item      o_item,
    output logic       o_full,
    output logic       o_empty
);

    t_item                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [QUEUE_AW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CW-1:0]  r_count,  n_count;

    assign o_full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];

    // Move pointers and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr + QUEUE_AW'(i_push);
        n_rd_ptr = r_rd_ptr + QUEUE_AW'(i_pop);
        n_count  = r_count + QUEUE_CW'(i_push) - QUEUE_CW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the pushed item
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // No overflow, no underflow
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push || i_pop)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("queue pop while empty");

    // Pointer distance tracks occupancy
    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_ptr - r_rd_ptr) == r_count[QUEUE_AW-1:0])
        else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

[design/crc32c_back.sv]
// Back end: folds queued words into the running CRC and registers the final value.
`default_nettype none

module crc32c_back
    import crc32c_pkg::*;
#(
    parameter int unsigned WORD_BYTES = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // seed register write
    input  wire logic             i_cfg_wr_en,
    input  wire logic [CRC_W-1:0] i_cfg_wr_data,
    // from the queue
    input  wire t_item            i_item,
    input  wire logic             i_empty,
    output logic                  o_pop,
    // output channel
    output logic                  o_valid,
    input  wire logic             i_stall,
    output logic [CRC_W-1:0]      o_crc_value
);

    logic [CRC_W-1:0] r_seed;
    logic [CRC_W-1:0] r_running, n_running;
    logic             r_out_valid, n_out_valid;
    logic [CRC_W-1:0] r_crc, n_crc;
    logic             out_free;

    assign out_free = !r_out_valid || !i_stall;
    // Stall only a last word whose result cannot be placed
    assign o_pop    = !i_empty && (!i_item.last || out_free);

    // Word update: per-byte steps flatten into one XOR network, gated by count
    always_comb begin
        logic [CRC_W-1:0]  c;
        logic [DATA_W-1:0] sh;
        c  = i_item.first ? ~r_seed : r_running;
        for (int i = 0; i < WORD_BYTES; i++) begin
            sh = i_item.data >> (8 * i);
            if (CNT_W'(i) < i_item.cnt) begin
                c = crc_byte(c, sh[7:0]);
            end
        end
        n_running   = o_pop ? c : r_running;
        n_out_valid = r_out_valid && i_stall;
        n_crc       = r_crc;
        if (o_pop && i_item.last) begin
            n_out_valid = 1'b1;
            n_crc       = ~c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed      <= '0;
            r_running   <= CRC_ONES;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_seed <= i_cfg_wr_data;
            end
            r_running   <= n_running;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_crc <= n_crc;
    end

    assign o_valid     = r_out_valid;
    assign o_crc_value = r_crc;

    // A popped last word always produces a result next cycle
    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && i_item.last |=> o_valid)
        else $error("last word popped without result");

    // A pending result is never overwritten while stalled
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |-> !(o_pop && i_item.last))
        else $error("result overwritten under stall");

    // Running register moves only when a word is consumed
    a_running_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_pop |=> $stable(r_running))
        else $error("running CRC changed without a word");

endmodule

`default_nettype wire
